// ===== design/pdrc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdrc_pkg
// Shared types and constants of the pickup and delivery route checker.
// ----------------------------------------------------------------------------
package pdrc_pkg;

    localparam int MAX_REQUESTS = 256;
    localparam int PICK_IW      = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;

    localparam int NODE_W   = 10;
    localparam int DEMAND_W = 16;
    localparam int LIMIT_W  = 15;
    localparam int COUNT_W  = 9;
    localparam int LOAD_W   = 17;
    localparam int STATUS_W = 3;
    localparam int CFG_IW   = 1;
    localparam int CFG_DW   = 15;

    localparam logic [NODE_W-1:0] POS_MAX = '1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 3'd0,
        ST_END_EARLY    = 3'd1,
        ST_NO_PICKUP    = 3'd2,
        ST_OVER_ENTRY   = 3'd3,
        ST_OVER_EXIT    = 3'd4,
        ST_WRONG_LENGTH = 3'd5,
        ST_BAD_NODE     = 3'd6
    } status_t;

    typedef enum logic [CFG_IW-1:0] {
        REG_REQUEST_COUNT    = 1'b0,
        REG_VEHICLE_CAPACITY = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [COUNT_W-1:0] n_eff;
        logic [NODE_W-1:0]  end_node;
        logic [LIMIT_W-1:0] capacity;
    } cfg_t;

    typedef struct packed {
        logic                       last;
        logic [LIMIT_W-1:0]         draught_limit;
        logic signed [DEMAND_W-1:0] demand;
        logic [NODE_W-1:0]          node;
    } item_t;

    typedef struct packed {
        logic                     route_done;
        logic signed [LOAD_W-1:0] load_after;
        status_t                  status;
    } result_t;

endpackage

// ===== design/pdrc_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdrc_cfg
// Configuration registers: clamped pair count, end depot index, capacity.
// ----------------------------------------------------------------------------
module pdrc_cfg (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [pdrc_pkg::CFG_IW-1:0]  cfg_index,
    input  logic [pdrc_pkg::CFG_DW-1:0]  cfg_data,
    output pdrc_pkg::cfg_t               cfg
);

    localparam logic [pdrc_pkg::COUNT_W-1:0] N_CAP =
        pdrc_pkg::COUNT_W'(pdrc_pkg::MAX_REQUESTS);

    pdrc_pkg::cfg_t cfg_reg;
    pdrc_pkg::cfg_t cfg_next;
    logic [pdrc_pkg::COUNT_W-1:0] count_wr;
    logic [pdrc_pkg::COUNT_W-1:0] n_wr;

    assign cfg_ready = 1'b1;
    assign count_wr  = cfg_data[pdrc_pkg::COUNT_W-1:0];

    always_comb begin
        // clamp the pair count to 1 .. MAX_REQUESTS
        if (count_wr == '0) begin
            n_wr = pdrc_pkg::COUNT_W'(1);
        end else if (32'(count_wr) > pdrc_pkg::MAX_REQUESTS) begin
            n_wr = N_CAP;
        end else begin
            n_wr = count_wr;
        end
    end

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (pdrc_pkg::cfg_index_t'(cfg_index))
                pdrc_pkg::REG_REQUEST_COUNT: begin
                    cfg_next.n_eff    = n_wr;
                    cfg_next.end_node = {n_wr, 1'b1};
                end
                pdrc_pkg::REG_VEHICLE_CAPACITY: begin
                    cfg_next.capacity = cfg_data[pdrc_pkg::LIMIT_W-1:0];
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.n_eff    <= pdrc_pkg::COUNT_W'(1);
            cfg_reg.end_node <= pdrc_pkg::NODE_W'(3);
            cfg_reg.capacity <= '1;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== design/pdrc_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdrc_check
// Per-node route checks and route state: load, pickup bitmap, position, error.
// ----------------------------------------------------------------------------
module pdrc_check (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  pdrc_pkg::item_t   item,
    input  pdrc_pkg::cfg_t    cfg,
    output pdrc_pkg::result_t result
);

    logic signed [pdrc_pkg::LOAD_W-1:0] load_reg;
    logic signed [pdrc_pkg::LOAD_W-1:0] load_next;
    logic [pdrc_pkg::MAX_REQUESTS-1:0]  seen_reg;
    logic [pdrc_pkg::MAX_REQUESTS-1:0]  seen_next;
    logic [pdrc_pkg::NODE_W-1:0]        pos_reg;
    logic [pdrc_pkg::NODE_W-1:0]        pos_next;
    pdrc_pkg::status_t                  err_reg;
    pdrc_pkg::status_t                  err_next;

    logic [pdrc_pkg::NODE_W-1:0]        pos;
    logic [pdrc_pkg::NODE_W-1:0]        n_ext;
    logic [pdrc_pkg::NODE_W-1:0]        dlv_off;
    logic [pdrc_pkg::NODE_W-1:0]        pick_off;
    logic [pdrc_pkg::LIMIT_W-1:0]       limit;
    logic signed [pdrc_pkg::LOAD_W-1:0] limit_s;
    logic signed [pdrc_pkg::LOAD_W:0]   sum;
    logic signed [pdrc_pkg::LOAD_W-1:0] new_load;
    logic                               is_pickup;
    logic                               is_delivery;
    pdrc_pkg::status_t                  err;

    assign pos      = (pos_reg == pdrc_pkg::POS_MAX) ? pos_reg : pos_reg + 1'b1;
    assign n_ext    = pdrc_pkg::NODE_W'(cfg.n_eff);
    assign dlv_off  = item.node - n_ext - 1'b1;
    assign pick_off = item.node - 1'b1;
    assign limit    = (item.draught_limit < cfg.capacity) ? item.draught_limit
                                                          : cfg.capacity;
    assign limit_s  = $signed(pdrc_pkg::LOAD_W'(limit));

    assign sum = $signed({load_reg[pdrc_pkg::LOAD_W-1], load_reg})
               + $signed((pdrc_pkg::LOAD_W + 1)'(item.demand));

    always_comb begin
        // saturate to the load range when the top two bits disagree
        case (sum[pdrc_pkg::LOAD_W:pdrc_pkg::LOAD_W-1])
            2'b01:   new_load = {1'b0, {(pdrc_pkg::LOAD_W-1){1'b1}}};
            2'b10:   new_load = {1'b1, {(pdrc_pkg::LOAD_W-1){1'b0}}};
            default: new_load = sum[pdrc_pkg::LOAD_W-1:0];
        endcase
    end

    assign is_pickup   = (item.node != '0) && (item.node <= n_ext);
    assign is_delivery = (item.node > n_ext) && (item.node < cfg.end_node);

    always_comb begin
        if (item.last && (pos != cfg.end_node)) begin
            err = pdrc_pkg::ST_WRONG_LENGTH;
        end else if ((item.node == cfg.end_node) && (pos < cfg.end_node)) begin
            err = pdrc_pkg::ST_END_EARLY;
        end else if (is_delivery && !seen_reg[pdrc_pkg::PICK_IW'(dlv_off)]) begin
            err = pdrc_pkg::ST_NO_PICKUP;
        end else if (item.node > cfg.end_node) begin
            err = pdrc_pkg::ST_BAD_NODE;
        end else if (load_reg > limit_s) begin
            err = pdrc_pkg::ST_OVER_ENTRY;
        end else if (new_load > limit_s) begin
            err = pdrc_pkg::ST_OVER_EXIT;
        end else begin
            err = pdrc_pkg::ST_OK;
        end
    end

    always_comb begin
        seen_next = seen_reg;
        if (is_pickup) begin
            seen_next[pdrc_pkg::PICK_IW'(pick_off)] = 1'b1;
        end
        err_next  = err_reg;
        load_next = load_reg;
        if (err_reg == pdrc_pkg::ST_OK) begin
            if (err != pdrc_pkg::ST_OK) begin
                err_next = err;
            end else begin
                load_next = new_load;
            end
        end
        pos_next = pos;
    end

    assign result.status     = err_next;
    assign result.load_after = load_next;
    assign result.route_done = item.last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_reg <= '0;
            seen_reg <= '0;
            pos_reg  <= '0;
            err_reg  <= pdrc_pkg::ST_OK;
        end else if (advance) begin
            if (item.last) begin
                // route over: drop all per-route state
                load_reg <= '0;
                seen_reg <= '0;
                pos_reg  <= '0;
                err_reg  <= pdrc_pkg::ST_OK;
            end else begin
                load_reg <= load_next;
                seen_reg <= seen_next;
                pos_reg  <= pos_next;
                err_reg  <= err_next;
            end
        end
    end

    a_error_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && !item.last && (err_reg != pdrc_pkg::ST_OK))
        |=> (err_reg == $past(err_reg)))
        else $error("first error changed inside a route");

    a_load_frozen: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && !item.last && (err_next != pdrc_pkg::ST_OK)) |=> $stable(load_reg))
        else $error("load moved after an error");

    a_route_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && item.last)
        |=> ((pos_reg == '0) && (seen_reg == '0) && (err_reg == pdrc_pkg::ST_OK)))
        else $error("route state not cleared after last item");

    a_pos_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(pos_reg))
        else $error("position advanced without an item");

endmodule

// ===== design/pickup_delivery_route_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pickup_delivery_route_check
// Streams route nodes and reports the sticky route status and load per node.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake            Payload
// s_*       in         s_tvalid/s_tready    node, demand, draught_limit; tlast=last
// m_*       out        m_tvalid/m_tready    status, load_after; tlast=route_done
// cfg_*     in         cfg_valid/cfg_ready  register index, write data
//
// One item per cycle while m_tready is high; m_tvalid is the result stage valid.
// All checks and the state update sit between the input and result registers,
// so the next node sees the state left by the previous one in the next cycle.
// Reset (aresetn low, synchronous) empties both stages and clears route state.
// A stalled m_tready holds the result; one more item waits in the input stage.
// ----------------------------------------------------------------------------
module pickup_delivery_route_check (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // [9:0] node, [25:10] demand, [40:26] draught_limit, [47:41] zero
    input  logic [47:0]                  s_tdata,
    input  logic                         s_tlast,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [2:0] status, [19:3] load_after, [23:20] zero
    output logic [23:0]                  m_tdata,
    output logic                         m_tlast,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [pdrc_pkg::CFG_IW-1:0]  cfg_index,
    input  logic [pdrc_pkg::CFG_DW-1:0]  cfg_data
);

    pdrc_pkg::cfg_t    cfg;
    pdrc_pkg::item_t   in_item_reg;
    pdrc_pkg::item_t   in_item_next;
    logic              in_valid_reg;
    logic              in_valid_next;
    pdrc_pkg::result_t out_res_reg;
    pdrc_pkg::result_t out_res_next;
    pdrc_pkg::result_t check_res;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              out_free;
    logic              advance;
    logic              s_accept;

    pdrc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pdrc_check u_check (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (check_res)
    );

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        in_item_next  = in_item_reg;
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_item_next.node          = s_tdata[9:0];
            in_item_next.demand        = $signed(s_tdata[25:10]);
            in_item_next.draught_limit = s_tdata[40:26];
            in_item_next.last          = s_tlast;
            in_valid_next              = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        out_res_next   = out_res_reg;
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_res_next   = check_res;
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_item_reg <= in_item_next;
        out_res_reg <= out_res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_res_reg.load_after, out_res_reg.status};
    assign m_tlast  = out_res_reg.route_done;

endmodule

// ===== sim/pickup_delivery_route_check_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pickup_delivery_route_check_tb
// Self-checking bench for the route checker. Route nodes go in through the
// stream input while the result stream is stalled at random. A local route
// model predicts status, load and route end for every accepted node, and the
// checker compares each result item with the oldest prediction.
// ----------------------------------------------------------------------------
module pickup_delivery_route_check_tb;
    import pdrc_pkg::*;

    localparam int STALL_LIMIT = 2000;

    // ways to spoil a generated route
    typedef enum int {
        FLAW_NONE,
        FLAW_SWAP,
        FLAW_DROP,
        FLAW_BAD_NODE,
        FLAW_EARLY_END,
        FLAW_REPEAT,
        FLAW_TIGHT_DRAUGHT
    } flaw_t;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata   = '0;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    cfg_index_t  cfg_index = REG_REQUEST_COUNT;
    logic [CFG_DW-1:0] cfg_data = '0;

    // route model state and its copy of the registers
    logic [COUNT_W-1:0]      cfg_pairs    = 9'd1;
    logic [LIMIT_W-1:0]      cfg_capacity = 15'h7fff;
    int                      route_load   = 0;
    logic [MAX_REQUESTS-1:0] picked       = '0;
    int                      route_pos    = 0;
    status_t                 route_err    = ST_OK;

    result_t expected_reports[$];
    int      mismatches  = 0;
    int      idle_cycles = 0;
    int      hold_left   = 0;
    bit      steady      = 1'b0;

    pickup_delivery_route_check dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic item_t mk(input int node, input int demand, input int draught,
                                 input bit last);
        item_t it;
        it.node          = NODE_W'(node);
        it.demand        = DEMAND_W'(demand);
        it.draught_limit = LIMIT_W'(draught);
        it.last          = last;
        return it;
    endfunction

    // Step the route state by one node and return the result it reports.
    function automatic result_t advance_route(input item_t it);
        int      n;
        int      end_node;
        int      node;
        int      limit;
        int      new_load;
        status_t err;
        result_t r;
        n = cfg_pairs;
        if (n == 0) n = 1;
        if (n > MAX_REQUESTS) n = MAX_REQUESTS;
        end_node = 2 * n + 1;
        node = it.node;
        route_pos = route_pos + 1;
        if (route_pos > POS_MAX) route_pos = POS_MAX;
        limit = cfg_capacity;
        if (int'(it.draught_limit) < limit) limit = it.draught_limit;
        new_load = route_load + int'(it.demand);
        if (new_load > 65535) new_load = 65535;
        if (new_load < -65536) new_load = -65536;

        err = ST_OK;
        if (it.last && route_pos != end_node)
            err = ST_WRONG_LENGTH;
        else if (node == end_node && route_pos < end_node)
            err = ST_END_EARLY;
        else if (node > n && node < end_node && !picked[(node - n - 1) % MAX_REQUESTS])
            err = ST_NO_PICKUP;
        else if (node > end_node)
            err = ST_BAD_NODE;
        else if (route_load > limit)
            err = ST_OVER_ENTRY;
        else if (new_load > limit)
            err = ST_OVER_EXIT;

        if (node >= 1 && node <= n) picked[(node - 1) % MAX_REQUESTS] = 1'b1;
        // first error sticks and freezes the load
        if (route_err == ST_OK) begin
            if (err != ST_OK) route_err = err;
            else route_load = new_load;
        end

        r.status     = route_err;
        r.load_after = LOAD_W'(route_load);
        r.route_done = it.last;
        if (it.last) begin
            route_load = 0;
            picked     = '0;
            route_pos  = 0;
            route_err  = ST_OK;
        end
        return r;
    endfunction

    task automatic push_node(input item_t it);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, it.draught_limit, it.demand, it.node};
        s_tlast  <= it.last;
        do @(posedge aclk); while (!s_tready);
        expected_reports.insert(expected_reports.size(), advance_route(it));
    endtask

    // An empty queue means the input is already idle.
    task automatic wait_drained;
        if (expected_reports.size() != 0) begin
            s_tvalid <= 1'b0;
            while (expected_reports.size() != 0) @(posedge aclk);
        end
    endtask

    // Write both registers back to back; call only while the block is idle.
    task automatic configure(input int pairs, input int capacity);
        cfg_valid <= 1'b1;
        cfg_index <= REG_REQUEST_COUNT;
        cfg_data  <= CFG_DW'(pairs & 'h1ff);
        do @(posedge aclk); while (!cfg_ready);
        cfg_pairs = COUNT_W'(pairs);
        cfg_index <= REG_VEHICLE_CAPACITY;
        cfg_data  <= CFG_DW'(capacity);
        do @(posedge aclk); while (!cfg_ready);
        cfg_capacity = LIMIT_W'(capacity);
        cfg_valid <= 1'b0;
    endtask

    function automatic int roomy_draught();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return 32767;
        if (r < 95) return $urandom_range(300, 32767);
        return $urandom_range(0, 300);
    endfunction

    // Build a well-formed route for n pairs, optionally spoil it, and send it.
    task automatic run_route(input int n, input flaw_t flaw, output int sent);
        item_t rt[$];
        int    pick_left[$];
        int    onboard[$];
        int    amt[MAX_REQUESTS];
        int    idx;
        int    nd;
        int    j;
        item_t it;
        for (int i = 1; i <= n; i++) begin
            pick_left.insert(pick_left.size(), i);
            amt[i-1] = $urandom_range(0, 400);
        end
        while (pick_left.size() != 0 || onboard.size() != 0) begin
            if (pick_left.size() != 0 && (onboard.size() == 0 || $urandom_range(0, 1))) begin
                idx = $urandom_range(0, pick_left.size() - 1);
                nd = pick_left[idx];
                pick_left.delete(idx);
                onboard.insert(onboard.size(), nd);
                rt.insert(rt.size(), mk(nd, amt[nd-1], roomy_draught(), 1'b0));
            end else begin
                idx = $urandom_range(0, onboard.size() - 1);
                nd = onboard[idx];
                onboard.delete(idx);
                rt.insert(rt.size(), mk(nd + n, -amt[nd-1], roomy_draught(), 1'b0));
            end
        end
        rt.insert(rt.size(),
                  mk(2 * n + 1, int'($urandom_range(0, 20)) - 10, roomy_draught(), 1'b1));

        j = $urandom_range(0, rt.size() - 2);
        case (flaw)
            FLAW_SWAP: begin
                idx = $urandom_range(0, rt.size() - 2);
                it = rt[idx];
                rt[idx] = rt[j];
                rt[j] = it;
            end
            FLAW_DROP: rt.delete(j);
            FLAW_BAD_NODE: rt[j].node = NODE_W'($urandom_range(0, 1023));
            FLAW_EARLY_END: rt.insert(j, mk(2 * n + 1, 0, 32767, 1'b0));
            FLAW_REPEAT: rt.insert(j, rt[j]);
            FLAW_TIGHT_DRAUGHT: rt[j].draught_limit = LIMIT_W'($urandom_range(0, 50));
            default: ;
        endcase
        foreach (rt[k]) push_node(rt[k]);
        sent = rt.size();
    endtask

    task automatic test_directed;
        // reset values: one pair, full capacity
        push_node(mk(1, 32767, 32767, 1'b0));
        push_node(mk(2, -32768, 32767, 1'b0));
        push_node(mk(3, 0, 32767, 1'b1));
        // delivery ahead of its pickup
        push_node(mk(2, 5, 32767, 1'b0));
        push_node(mk(1, 7, 32767, 1'b0));
        push_node(mk(3, 0, 32767, 1'b1));
        // end depot visited too soon
        push_node(mk(3, 0, 32767, 1'b0));
        push_node(mk(1, 1, 32767, 1'b0));
        push_node(mk(2, -1, 32767, 1'b1));
        // load over the draught on leaving
        push_node(mk(1, 10, 0, 1'b0));
        push_node(mk(2, -10, 32767, 1'b0));
        push_node(mk(3, 0, 32767, 1'b1));
        // node zero with the load already over its draught on entry
        push_node(mk(1, 100, 32767, 1'b0));
        push_node(mk(0, 0, 50, 1'b0));
        push_node(mk(3, 0, 32767, 1'b1));
        // nodes past the end depot
        push_node(mk(513, 0, 32767, 1'b0));
        push_node(mk(1023, 0, 32767, 1'b1));

        wait_drained();
        configure(0, 0);
        push_node(mk(1, -5, 32767, 1'b0));
        push_node(mk(2, 5, 0, 1'b0));
        push_node(mk(3, 0, 0, 1'b1));

        wait_drained();
        configure(511, 32767);
        push_node(mk(513, 0, 32767, 1'b0));
        push_node(mk(257, -1, 32767, 1'b1));

        // repeat pickup, then drive the load to its negative rail
        wait_drained();
        configure(256, 32767);
        push_node(mk(256, 40, 32767, 1'b0));
        push_node(mk(256, 40, 32767, 1'b0));
        push_node(mk(512, -80, 32767, 1'b0));
        repeat (3) push_node(mk(0, -32768, 32767, 1'b0));
        push_node(mk(0, 0, 32767, 1'b1));
    endtask

    // One route long enough to pin the position count at its ceiling.
    task automatic test_long_route;
        int nd;
        wait_drained();
        configure(1, 32767);
        for (int i = 0; i < 1030; i++) begin
            steady = (i < 500);
            nd = (i == 1024 || i == 1026) ? 3 : 0;
            if (i == 700) nd = 1;
            if (i == 701) nd = 2;
            push_node(mk(nd, int'($urandom_range(0, 200)) - 100, 32767, i == 1029));
        end
        steady = 1'b0;
    endtask

    task automatic test_random_routes;
        int n_raw;
        int n_eff;
        int cap;
        int made;
        int sent;
        int burst;
        for (int phase = 0; phase < 8; phase++) begin
            wait_drained();
            case (phase)
                0: n_raw = 0;
                1: n_raw = 1;
                default: n_raw = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 24)
                                                              : $urandom_range(2, 8);
            endcase
            case (phase)
                2: cap = 0;
                3: cap = 32767;
                default: cap = $urandom_range(0, 1) ? 32767 : $urandom_range(200, 3000);
            endcase
            configure(n_raw, cap);
            n_eff = (n_raw == 0) ? 1 : n_raw;
            steady = (phase == 4);
            made = 0;
            while (made < 105) begin
                if ($urandom_range(0, 9) < 8) begin
                    run_route(n_eff,
                              ($urandom_range(0, 3) == 0)
                                  ? flaw_t'($urandom_range(FLAW_SWAP, FLAW_TIGHT_DRAUGHT))
                                  : FLAW_NONE,
                              sent);
                    made += sent;
                end else begin
                    burst = $urandom_range(1, 4);
                    for (int k = 0; k < burst; k++)
                        push_node(mk($urandom_range(0, 1023), $urandom_range(0, 65535),
                                     $urandom_range(0, 32767),
                                     k == burst - 1 && $urandom_range(0, 1)));
                    made += burst;
                end
                // hold off until the pipe is empty now and then
                if ($urandom_range(0, 19) == 0) wait_drained();
            end
        end
        steady = 1'b0;
    endtask

    // result side back-pressure
    initial begin
        forever begin
            @(posedge aclk);
            if (steady) begin
                m_tready  <= 1'b1;
                hold_left = 0;
            end else if (hold_left != 0) begin
                hold_left--;
            end else if ($urandom_range(0, 9) < 7) begin
                m_tready  <= 1'b1;
                hold_left = $urandom_range(0, 6);
            end else begin
                m_tready  <= 1'b0;
                hold_left = pick_gap();
            end
        end
    end

    initial begin
        result_t got;
        result_t want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                got = result_t'({m_tlast, m_tdata[19:0]});
                if (expected_reports.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected result item: status %0d load %0d done %0b",
                                 got.status, got.load_after, got.route_done);
                    mismatches++;
                end else begin
                    want = expected_reports.pop_front();
                    if (got.status !== want.status || got.load_after !== want.load_after ||
                        got.route_done !== want.route_done) begin
                        if (mismatches < 10)
                            $display({"%0t: status exp %0d got %0d, load exp %0d got %0d,",
                                      " done exp %0b got %0b"},
                                     $realtime, want.status, got.status, want.load_after,
                                     got.load_after, want.route_done, got.route_done);
                        mismatches++;
                    end
                end
            end
        end
    end

    initial begin
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_long_route();
        test_random_routes();
        wait_drained();
        repeat (8) @(posedge aclk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
